@@ design/field_rotate_polarization_angles_macros.svh @@
// Assertion macros for the field rotation block
`ifndef FIELD_ROTATE_POLARIZATION_ANGLES_MACROS_SVH
`define FIELD_ROTATE_POLARIZATION_ANGLES_MACROS_SVH
// implication checked every clock outside reset
`define FRPA_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// implication checked in the cycle after the antecedent
`define FRPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ design/frpa_pkg.sv @@
// Package: shared types and constants for the field rotation block
package frpa_pkg;
	localparam int FieldW = 24;
	localparam int CoefW = 18;
	localparam int RegW = 54;
	localparam int ProjW = 44;
	localparam int MagW = 43;
	localparam int SqW = 86;
	localparam int SumW = 88;
	localparam int QW = 17;
	localparam int QSteps = 17;
	localparam logic [1:0] RegRowZero = 2'd0;
	localparam logic [1:0] RegRowOne = 2'd1;
	localparam logic [1:0] RegRowTwo = 2'd2;

	typedef struct packed {
		logic [SumW-1:0] num;
		logic [SumW-1:0] den;
		logic [QW-1:0] q;
	} div_lane_t;
endpackage

@@ design/field_rotate_polarization_angles.sv @@
// Throughput: one item per cycle; a single global stall holds all stages.
// Stages: 2 for the matrix product, 4 for squares, 17 restoring steps, 1 sign.
// Reset: arst_n clears all valid bits and loads the identity matrix.
// A stall at the output holds every stage, bubbles included.
// Top level: pipelined field rotation and polarization angle ratios
`include "field_rotate_polarization_angles_macros.svh"
module field_rotate_polarization_angles (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic signed [23:0] field_x,
	input logic signed [23:0] field_y,
	input logic signed [23:0] field_z,
	output logic out_valid,
	input logic out_stall,
	output logic [16:0] cos_sq_tilt,
	output logic signed [17:0] cos_two_phi,
	output logic signed [17:0] sin_two_phi,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [53:0] cfg_data
);
	localparam int Pre = 6;
	localparam int NS = frpa_pkg::QSteps;
	localparam int Depth = Pre + NS + 1;
	logic [frpa_pkg::RegW-1:0] row0_q, row1_q, row2_q;
	logic [Depth-1:0] vld_q;
	logic adv;
	logic signed [frpa_pkg::ProjW-1:0] px, py, pz;
	frpa_pkg::div_lane_t l0, l1, l2;
	frpa_pkg::div_lane_t lanes [NS+1][3];
	logic [2:0] flags [NS+1];
	logic zero, neg_c, neg_s;
	logic [16:0] qc, qs;

	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;
	assign out_valid = vld_q[Depth-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_q <= 54'd65536;
			row1_q <= 54'd65536 << 18;
			row2_q <= 54'd65536 << 36;
		end else if (cfg_we) begin
			unique case (cfg_index)
				frpa_pkg::RegRowZero: row0_q <= cfg_data;
				frpa_pkg::RegRowOne: row1_q <= cfg_data;
				frpa_pkg::RegRowTwo: row2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[Depth-2:0], in_valid};
		end
	end

	frpa_mac u_mac (
		.clk(clk), .adv(adv),
		.fx(field_x), .fy(field_y), .fz(field_z),
		.row0(row0_q), .row1(row1_q), .row2(row2_q),
		.px(px), .py(py), .pz(pz)
	);

	frpa_sq u_sq (
		.clk(clk), .adv(adv), .px(px), .py(py), .pz(pz),
		.lane0(l0), .lane1(l1), .lane2(l2),
		.zero(zero), .neg_c(neg_c), .neg_s(neg_s)
	);

	assign lanes[0][0] = l0;
	assign lanes[0][1] = l1;
	assign lanes[0][2] = l2;
	assign flags[0] = {zero, neg_c, neg_s};

	for (genvar k = 0; k < NS; k++) begin : g_div
		frpa_div_step u_step (
			.clk(clk), .adv(adv), .first(k == 0),
			.din(lanes[k]), .din_flags(flags[k]),
			.dout(lanes[k+1]), .dout_flags(flags[k+1])
		);
	end

	assign qc = lanes[NS][1].q;
	assign qs = lanes[NS][2].q;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (flags[NS][2]) begin
				cos_sq_tilt <= '0;
				cos_two_phi <= '0;
				sin_two_phi <= '0;
			end else begin
				cos_sq_tilt <= lanes[NS][0].q;
				cos_two_phi <= flags[NS][1] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
				sin_two_phi <= flags[NS][0] ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
			end
		end
	end

	`FRPA_ASSERT_IMPL(a_stall_holds, out_valid && out_stall, in_stall,
		"pipeline advanced under output stall")
	`FRPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(cos_sq_tilt) && $stable(sin_two_phi), "stalled item changed")
	`FRPA_ASSERT_IMPL(a_tilt_range, out_valid, cos_sq_tilt <= 17'd65536,
		"tilt ratio above one")
endmodule

@@ design/frpa_mac.sv @@
// Matrix product stage: rotates one field vector, two registered steps
module frpa_mac (
	input logic clk,
	input logic adv,
	input logic signed [frpa_pkg::FieldW-1:0] fx,
	input logic signed [frpa_pkg::FieldW-1:0] fy,
	input logic signed [frpa_pkg::FieldW-1:0] fz,
	input logic [frpa_pkg::RegW-1:0] row0,
	input logic [frpa_pkg::RegW-1:0] row1,
	input logic [frpa_pkg::RegW-1:0] row2,
	output logic signed [frpa_pkg::ProjW-1:0] px,
	output logic signed [frpa_pkg::ProjW-1:0] py,
	output logic signed [frpa_pkg::ProjW-1:0] pz
);
	localparam int PW = frpa_pkg::FieldW + frpa_pkg::CoefW;
	localparam int ProjW = frpa_pkg::ProjW;
	logic signed [PW-1:0] prod_s1 [9];
	logic signed [frpa_pkg::FieldW-1:0] f [3];
	logic [frpa_pkg::RegW-1:0] r [3];

	assign f[0] = fx;
	assign f[1] = fy;
	assign f[2] = fz;
	assign r[0] = row0;
	assign r[1] = row1;
	assign r[2] = row2;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s1[3*i+j] <= f[j] *
						$signed(r[j][frpa_pkg::CoefW*i +: frpa_pkg::CoefW]);
				end
			end
			px <= ProjW'(prod_s1[0]) + ProjW'(prod_s1[1]) + ProjW'(prod_s1[2]);
			py <= ProjW'(prod_s1[3]) + ProjW'(prod_s1[4]) + ProjW'(prod_s1[5]);
			pz <= ProjW'(prod_s1[6]) + ProjW'(prod_s1[7]) + ProjW'(prod_s1[8]);
		end
	end
endmodule

@@ design/frpa_sq.sv @@
// Square stage: magnitudes, squares, sums and numerators for the dividers
module frpa_sq (
	input logic clk,
	input logic adv,
	input logic signed [frpa_pkg::ProjW-1:0] px,
	input logic signed [frpa_pkg::ProjW-1:0] py,
	input logic signed [frpa_pkg::ProjW-1:0] pz,
	output frpa_pkg::div_lane_t lane0,
	output frpa_pkg::div_lane_t lane1,
	output frpa_pkg::div_lane_t lane2,
	output logic zero,
	output logic neg_c,
	output logic neg_s
);
	localparam int MW = frpa_pkg::MagW;
	localparam int SW = frpa_pkg::SqW;
	localparam int UW = frpa_pkg::SumW;
	localparam int LW = 22;
	localparam int HW = MW - LW;
	logic [MW-1:0] ax_s1, ay_s1, az_s1;
	logic sx_n_s1, sy_n_s1;
	logic [2*LW-1:0] xll_s2, yll_s2, zll_s2, pll_s2;
	logic [MW-1:0] xlh_s2, ylh_s2, zlh_s2, plh_s2, phl_s2;
	logic [2*HW-1:0] xhh_s2, yhh_s2, zhh_s2, phh_s2;
	logic sgn_s2;
	logic [SW-1:0] sx_s3, sy_s3, sz_s3, xy_s3;
	logic sgn_s3;
	logic [UW-1:0] pxy;

	assign pxy = UW'(sx_s3) + UW'(sy_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1 <= px[frpa_pkg::ProjW-1] ? MW'(-px) : MW'(px);
			ay_s1 <= py[frpa_pkg::ProjW-1] ? MW'(-py) : MW'(py);
			az_s1 <= pz[frpa_pkg::ProjW-1] ? MW'(-pz) : MW'(pz);
			sx_n_s1 <= px[frpa_pkg::ProjW-1];
			sy_n_s1 <= py[frpa_pkg::ProjW-1];
			xll_s2 <= (2*LW)'(ax_s1[LW-1:0]) * (2*LW)'(ax_s1[LW-1:0]);
			xlh_s2 <= MW'(ax_s1[LW-1:0]) * MW'(ax_s1[MW-1:LW]);
			xhh_s2 <= (2*HW)'(ax_s1[MW-1:LW]) * (2*HW)'(ax_s1[MW-1:LW]);
			yll_s2 <= (2*LW)'(ay_s1[LW-1:0]) * (2*LW)'(ay_s1[LW-1:0]);
			ylh_s2 <= MW'(ay_s1[LW-1:0]) * MW'(ay_s1[MW-1:LW]);
			yhh_s2 <= (2*HW)'(ay_s1[MW-1:LW]) * (2*HW)'(ay_s1[MW-1:LW]);
			zll_s2 <= (2*LW)'(az_s1[LW-1:0]) * (2*LW)'(az_s1[LW-1:0]);
			zlh_s2 <= MW'(az_s1[LW-1:0]) * MW'(az_s1[MW-1:LW]);
			zhh_s2 <= (2*HW)'(az_s1[MW-1:LW]) * (2*HW)'(az_s1[MW-1:LW]);
			pll_s2 <= (2*LW)'(ax_s1[LW-1:0]) * (2*LW)'(ay_s1[LW-1:0]);
			plh_s2 <= MW'(ax_s1[LW-1:0]) * MW'(ay_s1[MW-1:LW]);
			phl_s2 <= MW'(ax_s1[MW-1:LW]) * MW'(ay_s1[LW-1:0]);
			phh_s2 <= (2*HW)'(ax_s1[MW-1:LW]) * (2*HW)'(ay_s1[MW-1:LW]);
			sgn_s2 <= sx_n_s1 ^ sy_n_s1;
			sx_s3 <= (SW'(xhh_s2) << (2*LW)) + (SW'(xlh_s2) << (LW+1)) + SW'(xll_s2);
			sy_s3 <= (SW'(yhh_s2) << (2*LW)) + (SW'(ylh_s2) << (LW+1)) + SW'(yll_s2);
			sz_s3 <= (SW'(zhh_s2) << (2*LW)) + (SW'(zlh_s2) << (LW+1)) + SW'(zll_s2);
			xy_s3 <= (SW'(phh_s2) << (2*LW)) + ((SW'(plh_s2) + SW'(phl_s2)) << LW) +
				SW'(pll_s2);
			sgn_s3 <= sgn_s2;
			lane0.num <= pxy;
			lane0.den <= pxy + UW'(sz_s3);
			lane0.q <= '0;
			lane1.num <= (sx_s3 >= sy_s3) ? UW'(sx_s3 - sy_s3) : UW'(sy_s3 - sx_s3);
			lane1.den <= pxy;
			lane1.q <= '0;
			lane2.num <= {1'b0, xy_s3, 1'b0};
			lane2.den <= pxy;
			lane2.q <= '0;
			zero <= (pxy == '0);
			neg_c <= (sx_s3 < sy_s3);
			neg_s <= sgn_s3;
		end
	end
endmodule

@@ design/frpa_div_step.sv @@
// One restoring division step per stage, three lanes in parallel
module frpa_div_step (
	input logic clk,
	input logic adv,
	input logic first,
	input frpa_pkg::div_lane_t din [3],
	input logic [2:0] din_flags,
	output frpa_pkg::div_lane_t dout [3],
	output logic [2:0] dout_flags
);
	localparam int UW = frpa_pkg::SumW;
	logic [UW-1:0] n [3];
	logic [UW:0] d [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			n[i] = first ? din[i].num : {din[i].num[UW-2:0], 1'b0};
			d[i] = {1'b0, n[i]} - {1'b0, din[i].den};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				dout[i].den <= din[i].den;
				dout[i].num <= d[i][UW] ? n[i] : d[i][UW-1:0];
				dout[i].q <= {din[i].q[frpa_pkg::QW-2:0], ~d[i][UW]};
			end
			dout_flags <= din_flags;
		end
	end
endmodule
